@@ hw/rtl/keyed_entry_table_swap_remove_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyed entry table
// Shared helpers for writing clocked assertions with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_SWAP_REMOVE_UNIT_ASSERT_SVH
`define KEYED_ENTRY_TABLE_SWAP_REMOVE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KETSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("keyed entry table assertion failed");

// Next-cycle implication.
`define KETSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("keyed entry table assertion failed");

`endif

@@ hw/rtl/ketsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed entry table package
// Widths, command and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
package ketsr_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int PAY_W       = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 3'd0,
		CMD_READ_POS   = 3'd1,
		CMD_FIND_KEY   = 3'd2,
		CMD_REMOVE_POS = 3'd3,
		CMD_REMOVE_KEY = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOKEY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

endpackage

@@ hw/rtl/ketsr_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one table command per transaction.
// ----------------------------------------------------------------------------
interface ketsr_cmd_if;
	import ketsr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [KEY_W-1:0] order_key;
	logic [PAY_W-1:0]        order_payload;
	logic [IDX_W-1:0]        position;

	modport source (output valid, command, order_key, order_payload, position, input ready);
	modport sink (input valid, command, order_key, order_payload, position, output ready);
endinterface

@@ hw/rtl/ketsr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one command result per transaction.
// ----------------------------------------------------------------------------
interface ketsr_rsp_if;
	import ketsr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [IDX_W-1:0]        found_position;
	logic signed [KEY_W-1:0] out_key;
	logic [PAY_W-1:0]        out_payload;
	logic [CNT_W-1:0]        entry_count;

	modport source (output valid, status, found_position, out_key, out_payload, entry_count,
		input ready);
	modport sink (input valid, status, found_position, out_key, out_payload, entry_count,
		output ready);
endinterface

@@ hw/rtl/ketsr_store.sv @@
// ----------------------------------------------------------------------------
// Entry store
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module ketsr_store (
	input  logic               clk,
	input  ketsr_pkg::mem_req_t req,
	input  ketsr_pkg::entry_t   wr_data,
	output ketsr_pkg::entry_t   rd_data
);
	import ketsr_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

@@ hw/rtl/keyed_entry_table_swap_remove_unit.sv @@
// ----------------------------------------------------------------------------
// Keyed entry table with swap-remove
// A packed table of up to 64 key/payload entries with append, read, find and
// removal commands; a removal moves the last entry into the freed slot.
// ----------------------------------------------------------------------------
// One command is handled at a time. Append and any rejected command go from
// decode straight to the response state; a read or a removal at a position
// passes through a fetch state, and a removal of any entry but the last also
// through a move state. A key lookup reads one entry per cycle through the
// single memory read port and compares it with the shared key comparator; a
// find or a removal by key stops at the first match, and a miss scans all
// entry_count entries. The result sits in an output register, so the next
// command is accepted while it waits.
module keyed_entry_table_swap_remove_unit (
	input logic clk,
	input logic arst_n,
	ketsr_cmd_if.sink   cmd,
	ketsr_rsp_if.source rsp
);
	import ketsr_pkg::*;
	`include "keyed_entry_table_swap_remove_unit_assert.svh"

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_MOVE   = 7'b0010000,
		S_RESP   = 7'b0100000,
		S_SPARE  = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic                    rsp_valid_q;

	logic [CMD_W-1:0]        cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;
	logic [IDX_W-1:0]        pos_q;
	logic [IDX_W-1:0]        cmp_idx_q;

	status_t                 res_status_q;
	logic [IDX_W-1:0]        res_pos_q;
	logic signed [KEY_W-1:0] res_key_q;
	logic [PAY_W-1:0]        res_pay_q;

	logic [STATUS_W-1:0]     out_status_q;
	logic [IDX_W-1:0]        out_pos_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [PAY_W-1:0]        out_pay_q;
	logic [CNT_W-1:0]        out_count_q;

	mem_req_t                req;
	entry_t                  wr_data;
	entry_t                  rd_data;

	logic                    accept;
	logic                    can_load;
	logic                    full;
	logic                    empty;
	logic                    out_of_range;
	logic                    hit;
	logic [CNT_W-1:0]        count_m1;
	logic [IDX_W-1:0]        last_idx;
	logic                    is_rm_pos;
	logic                    is_rm_key;

	assign accept       = cmd.valid && cmd.ready;
	assign can_load     = !rsp_valid_q || rsp.ready;
	assign full         = (count_q == CNT_W'(TABLE_DEPTH));
	assign empty        = (count_q == '0);
	assign out_of_range = ({1'b0, pos_q} >= count_q);
	assign hit          = (rd_data.key == key_q);
	assign count_m1     = count_q - CNT_W'(1);
	assign last_idx     = count_m1[IDX_W-1:0];
	assign is_rm_pos    = (cmd_q == CMD_REMOVE_POS);
	assign is_rm_key    = (cmd_q == CMD_REMOVE_KEY);

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.out_key        = out_key_q;
	assign rsp.out_payload    = out_pay_q;
	assign rsp.entry_count    = out_count_q;

	always_comb begin
		req     = '0;
		wr_data = '{key: key_q, payload: pay_q};
		unique case (state_q)
			S_DECODE: begin
				case (cmd_q)
					CMD_APPEND: begin
						req.we      = !full;
						req.wr_addr = count_q[IDX_W-1:0];
					end
					CMD_READ_POS, CMD_REMOVE_POS: begin
						req.rd_en   = !out_of_range;
						req.rd_addr = pos_q;
					end
					CMD_FIND_KEY, CMD_REMOVE_KEY: begin
						req.rd_en   = !empty;
						req.rd_addr = '0;
					end
					default: begin
					end
				endcase
			end
			S_FETCH: begin
				req.rd_en   = is_rm_pos && (pos_q != last_idx);
				req.rd_addr = last_idx;
			end
			S_SCAN: begin
				if (hit) begin
					req.rd_en   = is_rm_key && (cmp_idx_q != last_idx);
					req.rd_addr = last_idx;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = cmp_idx_q + IDX_W'(1);
				end
			end
			S_MOVE: begin
				req.we      = 1'b1;
				req.wr_addr = res_pos_q;
				wr_data     = rd_data;
			end
			default: begin
			end
		endcase
	end

	ketsr_store u_store (
		.clk     (clk),
		.req     (req),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_RESP;
					case (cmd_q)
						CMD_APPEND: begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						CMD_READ_POS, CMD_REMOVE_POS: begin
							if (!out_of_range) begin
								state_q <= S_FETCH;
							end
						end
						CMD_FIND_KEY, CMD_REMOVE_KEY: begin
							if (!empty) begin
								state_q <= S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
				S_FETCH: begin
					state_q <= S_RESP;
					if (is_rm_pos) begin
						if (pos_q == last_idx) begin
							count_q <= count_m1;
						end else begin
							state_q <= S_MOVE;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_RESP;
						if (is_rm_key) begin
							if (cmp_idx_q == last_idx) begin
								count_q <= count_m1;
							end else begin
								state_q <= S_MOVE;
							end
						end
					end else if (cmp_idx_q == last_idx) begin
						state_q <= S_RESP;
					end
				end
				S_MOVE: begin
					count_q <= count_m1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (can_load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd.command;
					key_q <= cmd.order_key;
					pay_q <= cmd.order_payload;
					pos_q <= cmd.position;
				end
			end
			S_DECODE: begin
				res_status_q <= ST_OK;
				res_pos_q    <= '0;
				res_key_q    <= '0;
				res_pay_q    <= '0;
				cmp_idx_q    <= '0;
				case (cmd_q)
					CMD_APPEND: begin
						if (full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_pos_q <= count_q[IDX_W-1:0];
							res_key_q <= key_q;
							res_pay_q <= pay_q;
						end
					end
					CMD_READ_POS, CMD_REMOVE_POS: begin
						if (out_of_range) begin
							res_status_q <= ST_RANGE;
						end
					end
					CMD_FIND_KEY, CMD_REMOVE_KEY: begin
						if (empty) begin
							res_status_q <= ST_NOKEY;
						end
					end
					default: begin
					end
				endcase
			end
			S_FETCH: begin
				res_pos_q <= pos_q;
				res_key_q <= rd_data.key;
				res_pay_q <= rd_data.payload;
			end
			S_SCAN: begin
				if (hit) begin
					res_pos_q <= cmp_idx_q;
					res_key_q <= rd_data.key;
					res_pay_q <= rd_data.payload;
				end else if (cmp_idx_q == last_idx) begin
					res_status_q <= ST_NOKEY;
				end else begin
					cmp_idx_q <= cmp_idx_q + IDX_W'(1);
				end
			end
			S_RESP: begin
				if (can_load) begin
					out_status_q <= res_status_q;
					out_pos_q    <= res_pos_q;
					out_key_q    <= res_key_q;
					out_pay_q    <= res_pay_q;
					out_count_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	`KETSR_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`KETSR_ASSERT_NOW(a_scan_in_table, clk, arst_n, state_q == S_SCAN, {1'b0, cmp_idx_q} < count_q)
	`KETSR_ASSERT_NEXT(a_result_held, clk, arst_n, rsp_valid_q && !rsp.ready, rsp_valid_q && $stable(out_key_q) && $stable(out_count_q))
	`KETSR_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1))
	`KETSR_ASSERT_NOW(a_move_needs_entries, clk, arst_n, state_q == S_MOVE, count_q > CNT_W'(1))
endmodule

@@ tb/sv/ketsr_table_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed entry table checking package
// Transaction types and a scoreboard that keeps a shadow copy of the table,
// predicts the result of every accepted command and checks returned results.
// ----------------------------------------------------------------------------
package ketsr_table_check_pkg;
	import ketsr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		logic [IDX_W-1:0]        position;
	} table_cmd_t;

	typedef struct packed {
		status_t                 status;
		logic [IDX_W-1:0]        position;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		logic [CNT_W-1:0]        count;
	} table_result_t;

	class swap_table_scoreboard;
		logic signed [KEY_W-1:0] shadow_key[TABLE_DEPTH];
		logic [PAY_W-1:0]        shadow_payload[TABLE_DEPTH];
		int                      shadow_fill;
		int                      peak_fill;
		int                      failures;
		int                      cmd_seen[8];
		int                      status_seen[4];
		table_result_t           awaited_results[$];

		function new();
			shadow_fill = 0;
			peak_fill = 0;
			failures = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void note_command(table_cmd_t c);
			table_result_t r;
			int vacate;
			r = '0;
			r.status = ST_OK;
			vacate = -1;
			case (c.command)
			CMD_APPEND: begin
				if (shadow_fill == TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_key[shadow_fill] = c.key;
					shadow_payload[shadow_fill] = c.payload;
					r.position = IDX_W'(shadow_fill);
					r.key = c.key;
					r.payload = c.payload;
					shadow_fill++;
				end
			end
			CMD_READ_POS, CMD_REMOVE_POS: begin
				if (int'(c.position) >= shadow_fill) begin
					r.status = ST_RANGE;
				end else begin
					r.position = c.position;
					r.key = shadow_key[c.position];
					r.payload = shadow_payload[c.position];
					if (c.command == CMD_REMOVE_POS) vacate = c.position;
				end
			end
			CMD_FIND_KEY, CMD_REMOVE_KEY: begin
				r.status = ST_NOKEY;
				for (int i = 0; i < shadow_fill; i++) begin
					if (r.status == ST_NOKEY && shadow_key[i] == c.key) begin
						r.status = ST_OK;
						r.position = IDX_W'(i);
						r.key = shadow_key[i];
						r.payload = shadow_payload[i];
						if (c.command == CMD_REMOVE_KEY) vacate = i;
					end
				end
			end
			default: ;
			endcase
			// A removal fills the hole with the last entry and shrinks the table.
			if (vacate >= 0) begin
				shadow_key[vacate] = shadow_key[shadow_fill - 1];
				shadow_payload[vacate] = shadow_payload[shadow_fill - 1];
				shadow_fill--;
			end
			r.count = CNT_W'(shadow_fill);
			if (shadow_fill > peak_fill) peak_fill = shadow_fill;
			cmd_seen[c.command]++;
			status_seen[r.status]++;
			awaited_results.push_back(r);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("Unexpected result: status %0d pos %0d key %0d payload %h count %0d",
						got.status, got.position, got.key, got.payload, got.count);
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status || got.position !== want.position ||
					got.key !== want.key || got.payload !== want.payload ||
					got.count !== want.count) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("Mismatch: expected status %0d pos %0d key %0d payload %h count %0d",
						want.status, want.position, want.key, want.payload, want.count);
					$display("          actual   status %0d pos %0d key %0d payload %h count %0d",
						got.status, got.position, got.key, got.payload, got.count);
				end
			end
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void close_out();
			if (awaited_results.size() != 0) begin
				if (failures < REPORT_LIMIT)
					$display("%0d expected results never arrived", awaited_results.size());
				failures += awaited_results.size();
			end
		endfunction
	endclass

endpackage

@@ tb/sv/keyed_entry_table_swap_remove_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed entry table swap-remove unit testbench
// Drives directed corner commands and then random fill and drain sequences
// under three handshake idling profiles, predicting each result from a shadow
// table and comparing every returned transaction field by field.
// ----------------------------------------------------------------------------
module keyed_entry_table_swap_remove_unit_test;
	import ketsr_pkg::*;
	import ketsr_table_check_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   sender_idle_pct = 33;
	int   receiver_idle_pct = 77;
	bit   shrinking = 1'b0;

	swap_table_scoreboard shadow = new();

	ketsr_cmd_if cmd_ch();
	ketsr_rsp_if rsp_ch();

	keyed_entry_table_swap_remove_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_APPEND;
		cmd_ch.order_key = '0;
		cmd_ch.order_payload = '0;
		cmd_ch.position = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin : watch_results
		table_result_t seen;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.status = status_t'(rsp_ch.status);
			seen.position = rsp_ch.found_position;
			seen.key = rsp_ch.out_key;
			seen.payload = rsp_ch.out_payload;
			seen.count = rsp_ch.entry_count;
			shadow.check_result(seen);
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] op, input logic signed [KEY_W-1:0] k,
			input logic [PAY_W-1:0] p, input logic [IDX_W-1:0] at);
		table_cmd_t c;
		c.command = op;
		c.key = k;
		c.payload = p;
		c.position = at;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.order_key <= k;
		cmd_ch.order_payload <= p;
		cmd_ch.position <= at;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		shadow.note_command(c);
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (shadow.pending() != 0) @(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(int reuse_pct);
		int roll;
		roll = $urandom_range(99);
		if (shadow.shadow_fill > 0 && roll < reuse_pct)
			return shadow.shadow_key[$urandom_range(shadow.shadow_fill - 1)];
		if (roll < reuse_pct + 15)
			return $urandom_range(16) - 8;
		return $urandom;
	endfunction

	task automatic random_command();
		int roll;
		logic [CMD_W-1:0] op;
		logic [IDX_W-1:0] at;
		if (shadow.shadow_fill == TABLE_DEPTH && $urandom_range(3) == 0)
			shrinking = 1'b1;
		else if (shadow.shadow_fill <= 2 && $urandom_range(3) == 0)
			shrinking = 1'b0;
		roll = $urandom_range(99);
		if (!shrinking) begin
			if (roll < 65) op = CMD_APPEND;
			else if (roll < 75) op = CMD_READ_POS;
			else if (roll < 85) op = CMD_FIND_KEY;
			else if (roll < 92) op = CMD_REMOVE_POS;
			else if (roll < 99) op = CMD_REMOVE_KEY;
			else op = CMD_W'(CMD_SPARE_LO + $urandom_range(2));
		end else begin
			if (roll < 12) op = CMD_APPEND;
			else if (roll < 25) op = CMD_READ_POS;
			else if (roll < 40) op = CMD_FIND_KEY;
			else if (roll < 70) op = CMD_REMOVE_POS;
			else if (roll < 98) op = CMD_REMOVE_KEY;
			else op = CMD_W'(CMD_SPARE_LO + $urandom_range(2));
		end
		if (shadow.shadow_fill > 0 && $urandom_range(99) < 80)
			at = IDX_W'($urandom_range(shadow.shadow_fill - 1));
		else
			at = IDX_W'($urandom_range(TABLE_DEPTH - 1));
		send_command(op, pick_key(op == CMD_APPEND ? 25 : 75), $urandom, at);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		send_command(CMD_READ_POS, 0, 0, 0);
		send_command(CMD_REMOVE_POS, 0, 0, IDX_W'(TABLE_DEPTH - 1));
		send_command(CMD_FIND_KEY, 0, 0, 0);
		send_command(CMD_REMOVE_KEY, -1, 0, 0);
		send_command(CMD_APPEND, 32'sh8000_0000, 32'h0000_0000, 0);
		send_command(CMD_APPEND, 32'sh7fff_ffff, 32'hffff_ffff, 0);
		send_command(CMD_APPEND, 0, 32'ha5a5_a5a5, 0);
		send_command(CMD_APPEND, -1, 32'h5a5a_5a5a, 0);
		send_command(CMD_APPEND, 32'sh7fff_ffff, 32'h0000_0001, 0);
		send_command(CMD_FIND_KEY, 32'sh7fff_ffff, 0, 0);
		send_command(CMD_READ_POS, 0, 0, 4);
		send_command(CMD_READ_POS, 0, 0, 5);
		send_command(CMD_READ_POS, 0, 0, IDX_W'(TABLE_DEPTH - 1));
		send_command(CMD_REMOVE_KEY, 32'sh8000_0000, 0, 0);
		send_command(CMD_REMOVE_POS, 0, 0, 3);
		send_command(CMD_FIND_KEY, 32'sh7fff_ffff, 0, 0);
		send_command(CMD_FIND_KEY, 12345, 0, 0);
		send_command(CMD_REMOVE_KEY, 32'sh7fff_ffff, 0, 0);
		send_command(CMD_SPARE_LO, 7, 32'hdead_beef, 1);
		send_command(CMD_SPARE_MID, 7, 32'hdead_beef, 1);
		send_command(CMD_SPARE_HI, 7, 32'hdead_beef, 1);
		send_command(CMD_REMOVE_POS, 0, 0, 0);
		send_command(CMD_REMOVE_POS, 0, 0, 0);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				sender_idle_pct = 33;
				receiver_idle_pct = 77;
			end
			1: begin
				sender_idle_pct = 77;
				receiver_idle_pct = 33;
			end
			default: begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			endcase
			repeat (233) random_command();
			settle();
		end

		repeat (100) @(negedge clk);
		shadow.close_out();
		$display("Ran %0d commands: %0d appends, %0d reads, %0d finds, %0d position removals, %0d key removals, %0d unused codes.",
			shadow.cmd_seen.sum(), shadow.cmd_seen[CMD_APPEND], shadow.cmd_seen[CMD_READ_POS],
			shadow.cmd_seen[CMD_FIND_KEY], shadow.cmd_seen[CMD_REMOVE_POS],
			shadow.cmd_seen[CMD_REMOVE_KEY], shadow.cmd_seen[CMD_SPARE_LO] +
			shadow.cmd_seen[CMD_SPARE_MID] + shadow.cmd_seen[CMD_SPARE_HI]);
		$display("Outcomes: %0d ok, %0d key misses, %0d range rejects, %0d full drops; peak fill %0d of %0d.",
			shadow.status_seen[ST_OK], shadow.status_seen[ST_NOKEY],
			shadow.status_seen[ST_RANGE], shadow.status_seen[ST_FULL],
			shadow.peak_fill, TABLE_DEPTH);
		if (shadow.failures == 0) begin
			$display("keyed_entry_table_swap_remove_unit verification clean");
		end else begin
			$display("keyed_entry_table_swap_remove_unit verification failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("keyed_entry_table_swap_remove_unit verification failed");
		$finish;
	end

endmodule

@@ keyed_entry_table_swap_remove_unit.f @@
+incdir+hw/rtl
hw/rtl/ketsr_pkg.sv
hw/rtl/ketsr_cmd_if.sv
hw/rtl/ketsr_rsp_if.sv
hw/rtl/ketsr_store.sv
hw/rtl/keyed_entry_table_swap_remove_unit.sv
tb/sv/ketsr_table_check_pkg.sv
tb/sv/keyed_entry_table_swap_remove_unit_test.sv
